@@ hdl/wsm_pkg.sv @@
`default_nettype none

package wsm_pkg;

  // parameter defaults
  localparam int NUM_PATTERNS_DEF    = 4;
  localparam int WINDOW_MAX_DEF      = 16;
  localparam int MAX_PATTERN_LEN_DEF = 7;
  localparam int SYMBOL_BITS_DEF     = 8;

  // fixed field widths
  localparam int PAT_W       = 59;
  localparam int LABEL_W     = 32;
  localparam int WIN_W       = 5;
  localparam int AGE_W       = 5;
  localparam int TIME_W      = 32;
  localparam int SYM_FIELD_W = 8;
  localparam int CFG_W       = 59;
  localparam int CFG_IDX_W   = 3;
  localparam int PIDX_W      = 2;
  localparam int LBL_NIB_W   = 4;
  localparam int LEN_LSB     = 56;
  localparam int LEN_FIELD_W = 3;
  localparam int SYM_SEL_W   = 3;
  localparam int WIN_CAP     = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LABELS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd5;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd4;

  // per-cycle commands from the sequencer to a row of cells
  typedef struct packed {
    logic expire;
    logic pack;
    logic adv;
    logic shift;
  } cell_ctl_t;

  // row status back to the sequencer
  typedef struct packed {
    logic              packed_ok;
    logic              lane_any;
    logic              lane_rest;
    logic              lane0_v;
    logic [TIME_W-1:0] lane0_start;
  } row_stat_t;

  // symbol idx of a pattern word
  function automatic logic [SYM_FIELD_W-1:0] pat_sym(input logic [PAT_W-1:0] word,
                                                     input logic [SYM_SEL_W-1:0] idx);
    logic [PAT_W-1:0] sh;
    sh = word >> ({3'b000, idx} * 6'd8);
    return sh[SYM_FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/wsm_ifs.sv @@
`default_nettype none

interface wsm_item_if import wsm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SYM_FIELD_W-1:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink (input valid, input symbol, output ready);
endinterface

interface wsm_result_if import wsm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PIDX_W-1:0]    pattern_index;
  logic [LBL_NIB_W-1:0] group_id;
  logic [LBL_NIB_W-1:0] variant_id;
  logic [TIME_W-1:0]    match_start_time;
  logic [TIME_W-1:0]    match_end_time;
  logic                 last;

  modport source (output valid, output pattern_index, output group_id, output variant_id,
                  output match_start_time, output match_end_time, output last,
                  input ready);
  modport sink (input valid, input pattern_index, input group_id, input variant_id,
                input match_start_time, input match_end_time, input last,
                output ready);
endinterface

`default_nettype wire

@@ hdl/windowed_subsequence_matcher_core.sv @@
`default_nettype none

// Channel   Dir  Handshake      Payload
// items     in   valid/ready    symbol
// results   out  valid/ready    pattern_index, group_id, variant_id,
//                               match_start_time, match_end_time, last
// cfg       in   cfg_we         cfg_index, cfg_data (no read-back)
//
// An item passes through accept, pack moves and report drain: the accept cycle
// expires old entries, the pack phase closes holes in each row of cells one
// step per cycle, then starts and advances.
// Each pattern with completions drains its report lane through cell 0, one
// cell per cycle unless a stalled result holds it.
// Reset is synchronous: lists empty, item count zero, registers to defaults.
// A stalled result holds the report drain; items are taken only between items.

module windowed_subsequence_matcher_core import wsm_pkg::*; #(
  parameter int NUM_PATTERNS    = NUM_PATTERNS_DEF,
  parameter int WINDOW_MAX      = WINDOW_MAX_DEF,
  parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF,
  parameter int SYMBOL_BITS     = SYMBOL_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  wsm_item_if.sink             items,
  wsm_result_if.source         results,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_PACK   = 3'b010,
    ST_REPORT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [PAT_W-1:0]   pattern [4];
  logic [LABEL_W-1:0] pattern_labels;
  logic [WIN_W-1:0]   window_length;
  logic [AGE_W-1:0]   win_eff;

  logic [TIME_W-1:0]      time_counter;
  logic [TIME_W-1:0]      now;
  logic [SYMBOL_BITS-1:0] sym;

  cell_ctl_t ctl  [NUM_PATTERNS];
  row_stat_t stat [NUM_PATTERNS];

  logic                    accept;
  logic                    all_packed;
  logic                    all_empty;
  logic                    out_free;
  logic [NUM_PATTERNS-1:0] shift;
  logic [NUM_PATTERNS-1:0] above;
  logic                    seen;
  logic                    emit;
  logic [PIDX_W-1:0]       emit_index;
  logic [LBL_NIB_W-1:0]    emit_group;
  logic [LBL_NIB_W-1:0]    emit_variant;
  logic [TIME_W-1:0]       emit_start;
  logic                    emit_last;

  logic                 res_v;
  logic [PIDX_W-1:0]    res_index;
  logic [LBL_NIB_W-1:0] res_group;
  logic [LBL_NIB_W-1:0] res_variant;
  logic [TIME_W-1:0]    res_start;
  logic [TIME_W-1:0]    res_end;
  logic                 res_last;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern[0]     <= '0;
      pattern[1]     <= '0;
      pattern[2]     <= '0;
      pattern[3]     <= '0;
      pattern_labels <= '0;
      window_length  <= WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_0: pattern[0]     <= cfg_data[PAT_W-1:0];
        REG_PATTERN_1: pattern[1]     <= cfg_data[PAT_W-1:0];
        REG_PATTERN_2: pattern[2]     <= cfg_data[PAT_W-1:0];
        REG_PATTERN_3: pattern[3]     <= cfg_data[PAT_W-1:0];
        REG_LABELS:    pattern_labels <= cfg_data[LABEL_W-1:0];
        REG_WINDOW:    window_length  <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything past the cap acts as the cap
  always_comb begin
    priority if (window_length == '0) begin
      win_eff = AGE_W'(1);
    end else if (window_length > WIN_W'(WIN_CAP)) begin
      win_eff = AGE_W'(WIN_CAP);
    end else begin
      win_eff = AGE_W'(window_length);
    end
  end

  assign items.ready = (state == ST_IDLE);
  assign accept      = items.valid && items.ready;
  assign out_free    = !res_v || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_counter <= '0;
    end else if (accept) begin
      time_counter <= time_counter + TIME_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now <= time_counter;
      sym <= items.symbol[SYMBOL_BITS-1:0];
    end
  end

  always_comb begin
    all_packed = 1'b1;
    all_empty  = 1'b1;
    for (int k = 0; k < NUM_PATTERNS; k++) begin
      all_packed = all_packed && stat[k].packed_ok;
      all_empty  = all_empty && !stat[k].lane_any;
    end
  end

  always_comb begin
    above[NUM_PATTERNS-1] = 1'b0;
    for (int k = NUM_PATTERNS - 2; k >= 0; k--) begin
      above[k] = above[k+1] || stat[k+1].lane_any;
    end
  end

  // drain the lowest pattern that still holds completions
  always_comb begin
    seen         = 1'b0;
    emit         = 1'b0;
    emit_index   = '0;
    emit_group   = '0;
    emit_variant = '0;
    emit_start   = '0;
    emit_last    = 1'b0;
    for (int k = 0; k < NUM_PATTERNS; k++) begin
      shift[k] = 1'b0;
      if ((state == ST_REPORT) && stat[k].lane_any && !seen) begin
        seen = 1'b1;
        if (!stat[k].lane0_v || out_free) begin
          shift[k] = 1'b1;
        end
        if (stat[k].lane0_v && out_free) begin
          emit         = 1'b1;
          emit_index   = PIDX_W'(k);
          emit_group   = pattern_labels[8*k+4 +: LBL_NIB_W];
          emit_variant = pattern_labels[8*k +: LBL_NIB_W];
          emit_start   = stat[k].lane0_start;
          emit_last    = !stat[k].lane_rest && !above[k];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_PATTERNS; k++) begin
      ctl[k].expire = accept;
      ctl[k].pack   = (state == ST_PACK) && !all_packed;
      ctl[k].adv    = (state == ST_PACK) && all_packed;
      ctl[k].shift  = shift[k];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_PACK;
      ST_PACK:   if (all_packed) state_next = ST_REPORT;
      ST_REPORT: if (all_empty) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  for (genvar k = 0; k < NUM_PATTERNS; k++) begin : g_row
    wsm_row #(
      .WINDOW_MAX      (WINDOW_MAX),
      .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
      .SYMBOL_BITS     (SYMBOL_BITS)
    ) u_row (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl[k]),
      .word (pattern[k]),
      .win  (win_eff),
      .sym  (sym),
      .now  (now),
      .stat (stat[k])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (emit) begin
      res_v <= 1'b1;
    end else if (results.ready) begin
      res_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_index   <= emit_index;
      res_group   <= emit_group;
      res_variant <= emit_variant;
      res_start   <= emit_start;
      res_end     <= now;
      res_last    <= emit_last;
    end
  end

  assign results.valid            = res_v;
  assign results.pattern_index    = res_index;
  assign results.group_id         = res_group;
  assign results.variant_id       = res_variant;
  assign results.match_start_time = res_start;
  assign results.match_end_time   = res_end;
  assign results.last             = res_last;

endmodule

`default_nettype wire

@@ hdl/wsm_cell.sv @@
`default_nettype none

module wsm_cell import wsm_pkg::*; #(
  parameter int PROG_W      = 3,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cell_ctl_t              ctl,
  input  logic [PAT_W-1:0]       word,
  input  logic [PROG_W-1:0]      len,
  input  logic [AGE_W-1:0]       win,
  input  logic [SYMBOL_BITS-1:0] sym,
  input  logic [TIME_W-1:0]      now,
  input  logic                   start_en,
  input  logic                   dn_v,
  input  logic                   up_v,
  input  logic [TIME_W-1:0]      up_start,
  input  logic [AGE_W-1:0]       up_age,
  input  logic [PROG_W-1:0]      up_prog,
  input  logic                   up_lane_v,
  input  logic [TIME_W-1:0]      up_lane_start,
  output logic                   v,
  output logic [TIME_W-1:0]      start,
  output logic [AGE_W-1:0]       age,
  output logic [PROG_W-1:0]      prog,
  output logic                   lane_v,
  output logic [TIME_W-1:0]      lane_start
);

  logic [AGE_W-1:0]       age_inc;
  logic                   drop;
  logic                   move_in;
  logic                   move_out;
  logic [SYM_FIELD_W-1:0] psym;
  logic                   hit;
  logic [PROG_W-1:0]      prog_inc;
  logic                   done_adv;
  logic                   new_done;

  assign age_inc  = age + AGE_W'(1);
  assign drop     = (age_inc >= win) || (prog >= len);
  assign move_in  = !v && up_v;
  assign move_out = v && !dn_v;
  assign psym     = pat_sym(word, SYM_SEL_W'(prog));
  assign hit      = (psym[SYMBOL_BITS-1:0] == sym);
  assign prog_inc = prog + PROG_W'(hit);
  assign done_adv = (prog_inc >= len);
  // a fresh entry has already matched the first symbol
  assign new_done = (len == PROG_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      v      <= 1'b0;
      lane_v <= 1'b0;
    end else begin
      if (ctl.expire) begin
        if (v && drop) begin
          v <= 1'b0;
        end else begin
          age <= age_inc;
        end
      end else if (ctl.pack) begin
        // let holes rise one cell per cycle
        if (move_in) begin
          v     <= 1'b1;
          start <= up_start;
          age   <= up_age;
          prog  <= up_prog;
        end else if (move_out) begin
          v <= 1'b0;
        end
      end else if (ctl.adv) begin
        if (v) begin
          if (done_adv) begin
            v          <= 1'b0;
            lane_v     <= 1'b1;
            lane_start <= start;
          end else begin
            prog <= prog_inc;
          end
        end else if (start_en && dn_v) begin
          if (new_done) begin
            lane_v     <= 1'b1;
            lane_start <= now;
          end else begin
            v     <= 1'b1;
            start <= now;
            age   <= '0;
            prog  <= PROG_W'(1);
          end
        end
      end else if (ctl.shift) begin
        // drain completed items toward cell 0
        lane_v     <= up_lane_v;
        lane_start <= up_lane_start;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/wsm_row.sv @@
`default_nettype none

module wsm_row import wsm_pkg::*; #(
  parameter int WINDOW_MAX      = WINDOW_MAX_DEF,
  parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF,
  parameter int SYMBOL_BITS     = SYMBOL_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cell_ctl_t              ctl,
  input  logic [PAT_W-1:0]       word,
  input  logic [AGE_W-1:0]       win,
  input  logic [SYMBOL_BITS-1:0] sym,
  input  logic [TIME_W-1:0]      now,
  output row_stat_t              stat
);

  localparam int PROG_W = $clog2(MAX_PATTERN_LEN + 1);

  logic [LEN_FIELD_W-1:0] len_raw;
  logic [PROG_W-1:0]      len;
  logic [SYM_FIELD_W-1:0] sym0;
  logic                   start_en;

  logic [WINDOW_MAX:0]    v;
  logic [WINDOW_MAX-1:0]  dn_v;
  logic [WINDOW_MAX:0]    lane_v;
  logic [TIME_W-1:0]      start_a      [WINDOW_MAX+1];
  logic [AGE_W-1:0]       age_a        [WINDOW_MAX+1];
  logic [PROG_W-1:0]      prog_a       [WINDOW_MAX+1];
  logic [TIME_W-1:0]      lane_start_a [WINDOW_MAX+1];

  assign len_raw  = word[LEN_LSB +: LEN_FIELD_W];
  assign len      = (len_raw > LEN_FIELD_W'(MAX_PATTERN_LEN)) ? PROG_W'(MAX_PATTERN_LEN)
                                                              : PROG_W'(len_raw);
  assign sym0     = pat_sym(word, '0);
  assign start_en = (len != '0) && (sym0[SYMBOL_BITS-1:0] == sym);

  // the slot above the top cell is always empty
  assign v[WINDOW_MAX]            = 1'b0;
  assign lane_v[WINDOW_MAX]       = 1'b0;
  assign start_a[WINDOW_MAX]      = '0;
  assign age_a[WINDOW_MAX]        = '0;
  assign prog_a[WINDOW_MAX]       = '0;
  assign lane_start_a[WINDOW_MAX] = '0;
  assign dn_v = {v[WINDOW_MAX-2:0], 1'b1};

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    wsm_cell #(
      .PROG_W      (PROG_W),
      .SYMBOL_BITS (SYMBOL_BITS)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctl           (ctl),
      .word          (word),
      .len           (len),
      .win           (win),
      .sym           (sym),
      .now           (now),
      .start_en      (start_en),
      .dn_v          (dn_v[i]),
      .up_v          (v[i+1]),
      .up_start      (start_a[i+1]),
      .up_age        (age_a[i+1]),
      .up_prog       (prog_a[i+1]),
      .up_lane_v     (lane_v[i+1]),
      .up_lane_start (lane_start_a[i+1]),
      .v             (v[i]),
      .start         (start_a[i]),
      .age           (age_a[i]),
      .prog          (prog_a[i]),
      .lane_v        (lane_v[i]),
      .lane_start    (lane_start_a[i])
    );
  end

  assign stat.packed_ok   = ((~v[WINDOW_MAX-1:0] & v[WINDOW_MAX:1]) == '0);
  assign stat.lane_any    = |lane_v[WINDOW_MAX-1:0];
  assign stat.lane_rest   = |lane_v[WINDOW_MAX-1:1];
  assign stat.lane0_v     = lane_v[0];
  assign stat.lane0_start = lane_start_a[0];

endmodule

`default_nettype wire

@@ hdl/wsm_checker.sv @@
`default_nettype none

module wsm_checker import wsm_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [PIDX_W-1:0]    out_index,
  input logic [LBL_NIB_W-1:0] out_group,
  input logic [LBL_NIB_W-1:0] out_variant,
  input logic [TIME_W-1:0]    out_start,
  input logic [TIME_W-1:0]    out_end_time,
  input logic                 out_last
);

  logic [TIME_W-1:0] span;

  assign span = out_end_time - out_start;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({out_index, out_group, out_variant,
                                                      out_start, out_end_time, out_last}))
    else $error("stalled result changed or dropped");

  // an item always passes through pack and report before the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input ready too early after an item");

  // a match never spans more than the window cap
  a_span: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> span < TIME_W'(WIN_CAP))
    else $error("match span exceeds window");

endmodule

bind windowed_subsequence_matcher_core wsm_checker u_wsm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (items.valid),
  .in_ready     (items.ready),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .out_index    (results.pattern_index),
  .out_group    (results.group_id),
  .out_variant  (results.variant_id),
  .out_start    (results.match_start_time),
  .out_end_time (results.match_end_time),
  .out_last     (results.last)
);

`default_nettype wire

@@ bench/tb.sv @@
`default_nettype none

module tb import wsm_pkg::*; ();

  typedef struct packed {
    logic [PIDX_W-1:0]    pattern_index;
    logic [LBL_NIB_W-1:0] group_id;
    logic [LBL_NIB_W-1:0] variant_id;
    logic [TIME_W-1:0]    match_start_time;
    logic [TIME_W-1:0]    match_end_time;
    logic                 last;
  } match_rep_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  wsm_item_if   item_ch ();
  wsm_result_if result_ch ();

  windowed_subsequence_matcher_core dut (
    .clk       (clk),
    .rst       (rst),
    .items     (item_ch),
    .results   (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of the registers and the partial-match lists
  logic [PAT_W-1:0]       pat_reg [NUM_PATTERNS_DEF];
  logic [LABEL_W-1:0]     label_reg;
  logic [WIN_W-1:0]       win_reg;
  logic [TIME_W-1:0]      item_clock;
  bit                     live     [NUM_PATTERNS_DEF][WIN_CAP];
  logic [TIME_W-1:0]      born     [NUM_PATTERNS_DEF][WIN_CAP];
  logic [LEN_FIELD_W-1:0] step_idx [NUM_PATTERNS_DEF][WIN_CAP];

  logic [SYM_FIELD_W-1:0] symbol_backlog [$];
  match_rep_t             pending_matches [$];
  match_rep_t             want;
  logic [SYM_FIELD_W-1:0] alphabet [4];
  int                     mismatch_count;
  int                     send_gap_pct;
  int                     recv_gap_pct;

  function automatic void predict_matches(input logic [SYM_FIELD_W-1:0] sym);
    logic [TIME_W-1:0]      now;
    logic [TIME_W-1:0]      st [WIN_CAP];
    int unsigned            pr [WIN_CAP];
    int unsigned            win, len, cnt, kept, p;
    int                     k, j;
    logic [7:0]             lbl;
    match_rep_t             held;
    bit                     have_held;
    now = item_clock;
    win = win_reg;
    if (win < 1) win = 1;
    if (win > WIN_CAP) win = WIN_CAP;
    have_held = 1'b0;
    held = '0;
    for (k = 0; k < NUM_PATTERNS_DEF; k++) begin
      len = pat_reg[k][LEN_LSB +: LEN_FIELD_W];
      lbl = label_reg[8*k +: 8];
      cnt = 0;
      // drop aged-out entries and entries the current length no longer allows
      for (j = 0; j < WIN_CAP; j++) begin
        if (live[k][j] && (now - born[k][j]) < win && step_idx[k][j] < len) begin
          st[cnt] = born[k][j];
          pr[cnt] = step_idx[k][j];
          cnt++;
        end
      end
      if (len > 0 && sym == pat_reg[k][7:0] && cnt < WIN_CAP) begin
        st[cnt] = now;
        pr[cnt] = 0;
        cnt++;
      end
      kept = 0;
      for (j = 0; j < cnt; j++) begin
        p = pr[j];
        if (pat_reg[k][8*p +: 8] == sym) p++;
        if (p >= len) begin
          if (have_held) pending_matches.push_back(held);
          held.pattern_index    = PIDX_W'(k);
          held.group_id         = lbl[7:4];
          held.variant_id       = lbl[3:0];
          held.match_start_time = st[j];
          held.match_end_time   = now;
          held.last             = 1'b0;
          have_held = 1'b1;
        end else begin
          st[kept] = st[j];
          pr[kept] = p;
          kept++;
        end
      end
      for (j = 0; j < WIN_CAP; j++) begin
        live[k][j] = (j < kept);
        if (j < kept) begin
          born[k][j]     = st[j];
          step_idx[k][j] = LEN_FIELD_W'(pr[j]);
        end
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      pending_matches.push_back(held);
    end
    item_clock = now + 1;
  endfunction

  function automatic void check_field(input string name, input logic [TIME_W-1:0] want_v,
                                      input logic [TIME_W-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  function automatic logic [SYM_FIELD_W-1:0] noise_symbol();
    if ($urandom_range(1) == 0) return alphabet[$urandom_range(3)];
    return SYM_FIELD_W'($urandom_range(255));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    case (idx)
      REG_PATTERN_0, REG_PATTERN_1,
      REG_PATTERN_2, REG_PATTERN_3: pat_reg[idx] = value[PAT_W-1:0];
      REG_LABELS:                   label_reg = value[LABEL_W-1:0];
      REG_WINDOW:                   win_reg = value[WIN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // wait for all items taken and all reports back, then let the block go idle
  task automatic settle();
    while (symbol_backlog.size() != 0 || pending_matches.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_phase(input int n_items, input int phase_no);
    logic [CFG_W-1:0] word;
    int unsigned      len;
    int               k, i, count;
    for (i = 0; i < 4; i++) alphabet[i] = SYM_FIELD_W'($urandom_range(255));
    for (k = 0; k < NUM_PATTERNS_DEF; k++) begin
      if ($urandom_range(9) < 8) begin
        word = CFG_W'({$urandom, $urandom});
        len = $urandom_range(7);
        word[LEN_LSB +: LEN_FIELD_W] = LEN_FIELD_W'(len);
        for (i = 0; i < len; i++) word[8*i +: 8] = alphabet[$urandom_range(3)];
        write_reg(REG_PATTERN_0 + CFG_IDX_W'(k), word);
      end
    end
    if ($urandom_range(9) < 7) write_reg(REG_LABELS, CFG_W'($urandom));
    case (phase_no)
      0: write_reg(REG_WINDOW, CFG_W'(0));
      1: write_reg(REG_WINDOW, CFG_W'(1));
      2: write_reg(REG_WINDOW, CFG_W'(WIN_CAP));
      default: begin
        if ($urandom_range(1) == 0) write_reg(REG_WINDOW, CFG_W'($urandom_range(17, 31)));
        else write_reg(REG_WINDOW, CFG_W'($urandom_range(2, 15)));
      end
    endcase
    // mostly whole pattern sequences with noise mixed in
    count = 0;
    while (count < n_items) begin
      if ($urandom_range(9) < 7) begin
        k = $urandom_range(NUM_PATTERNS_DEF - 1);
        len = pat_reg[k][LEN_LSB +: LEN_FIELD_W];
        for (i = 0; i < len; i++) begin
          if ($urandom_range(3) == 0) begin
            symbol_backlog.push_back(noise_symbol());
            count++;
          end
          symbol_backlog.push_back(pat_reg[k][8*i +: 8]);
          count++;
        end
      end else begin
        symbol_backlog.push_back(noise_symbol());
        count++;
      end
    end
    settle();
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        predict_matches(item_ch.symbol);
        symbol_backlog.delete(0);
      end
      // hold an item until it is taken
      if (!item_ch.valid || item_ch.ready) begin
        if (symbol_backlog.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          item_ch.valid  <= 1'b1;
          item_ch.symbol <= symbol_backlog[0];
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // report monitor
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (pending_matches.size() == 0) begin
          $display("%0t: unexpected report pattern_index %0d start %0d end %0d", $time,
                   result_ch.pattern_index, result_ch.match_start_time,
                   result_ch.match_end_time);
          mismatch_count++;
        end else begin
          want = pending_matches.pop_front();
          check_field("pattern_index", TIME_W'(want.pattern_index),
                      TIME_W'(result_ch.pattern_index));
          check_field("group_id", TIME_W'(want.group_id), TIME_W'(result_ch.group_id));
          check_field("variant_id", TIME_W'(want.variant_id), TIME_W'(result_ch.variant_id));
          check_field("match_start_time", want.match_start_time, result_ch.match_start_time);
          check_field("match_end_time", want.match_end_time, result_ch.match_end_time);
          check_field("last", TIME_W'(want.last), TIME_W'(result_ch.last));
        end
      end
      result_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  initial begin
    int i, k;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    item_ch.valid   = 1'b0;
    item_ch.symbol  = '0;
    result_ch.ready = 1'b0;
    mismatch_count  = 0;
    send_gap_pct    = 34;
    recv_gap_pct    = 66;
    for (k = 0; k < NUM_PATTERNS_DEF; k++) begin
      pat_reg[k] = '0;
      for (i = 0; i < WIN_CAP; i++) begin
        live[k][i]     = 1'b0;
        born[k][i]     = '0;
        step_idx[k][i] = '0;
      end
    end
    label_reg  = '0;
    win_reg    = WINDOW_RESET;
    item_clock = '0;
    for (i = 0; i < 4; i++) alphabet[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // length one, mid length, full length and a disabled pattern; window above range
    write_reg(REG_PATTERN_0, {3'd1, 48'h123456789ABC, 8'hFF});
    write_reg(REG_PATTERN_1, {3'd3, 32'hDEADBEEF, 8'hA5, 8'h5A, 8'h00});
    write_reg(REG_PATTERN_2, {3'd7, 56'h77665544332211});
    write_reg(REG_PATTERN_3, {3'd0, 48'h0, 8'h00});
    write_reg(REG_LABELS, CFG_W'(32'h00FF0FF0));
    write_reg(REG_WINDOW, CFG_W'(31));
    foreach (alphabet[i]) alphabet[i] = 8'h00;
    symbol_backlog = '{8'hFF, 8'h00, 8'h5A, 8'h11, 8'h22, 8'hA5,
                       8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'hFF};
    settle();

    // every pattern builds fifteen open entries, then one symbol completes them all
    for (k = 0; k < NUM_PATTERNS_DEF; k++)
      write_reg(REG_PATTERN_0 + CFG_IDX_W'(k), {3'd2, 40'h0, 8'hC3, 8'h3C});
    write_reg(REG_LABELS, CFG_W'($urandom));
    write_reg(REG_WINDOW, CFG_W'(WIN_CAP));
    for (i = 0; i < 15; i++) symbol_backlog.push_back(8'h3C);
    symbol_backlog.push_back(8'hC3);
    settle();

    for (i = 0; i < 9; i++) begin
      if (i < 3) begin
        send_gap_pct = 34;
        recv_gap_pct = 66;
      end else if (i < 6) begin
        send_gap_pct = 66;
        recv_gap_pct = 34;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      random_phase(22, i);
    end

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ windowed_subsequence_matcher_core.f @@
hdl/wsm_pkg.sv
hdl/wsm_ifs.sv
hdl/wsm_cell.sv
hdl/wsm_row.sv
hdl/windowed_subsequence_matcher_core.sv
hdl/wsm_checker.sv
bench/tb.sv
